/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_PROP(lbl, clk_e, rst_n_e, prop) \
    lbl: assert property (@(posedge clk_e) disable iff (!rst_n_e) prop) \
        else $error("assertion failed");

// check that an antecedent is followed by a consequent in the next cycle
`define ASSERT_NEXT(lbl, clk_e, rst_n_e, ante, cons) \
    lbl: assert property (@(posedge clk_e) disable iff (!rst_n_e) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Beat types, bus step codes, command codes and configuration indexes.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    localparam int TICK_COUNT_WIDTH = 16;
    localparam int QPT_W            = 16;
    localparam int AWL_W            = 8;
    localparam int CFG_DATA_W       = 16;
    localparam int CMP_W = ((TICK_COUNT_WIDTH > QPT_W) ? TICK_COUNT_WIDTH : QPT_W) + 1;

    localparam logic       CFG_QPT = 1'b0;
    localparam logic       CFG_AWL = 1'b1;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_ST_A      = 4'd1;
    localparam logic [3:0] PH_ST_B      = 4'd2;
    localparam logic [3:0] PH_ST_C      = 4'd3;
    localparam logic [3:0] PH_ST_D      = 4'd4;
    localparam logic [3:0] PH_SP_A      = 4'd5;
    localparam logic [3:0] PH_SP_B      = 4'd6;
    localparam logic [3:0] PH_SP_C      = 4'd7;
    localparam logic [3:0] PH_BIT_LOW   = 4'd8;
    localparam logic [3:0] PH_BIT_SET   = 4'd9;
    localparam logic [3:0] PH_BIT_HIGH  = 4'd10;
    localparam logic [3:0] PH_BIT_HOLD  = 4'd11;
    localparam logic [3:0] PH_TAIL_LOW  = 4'd12;
    localparam logic [3:0] PH_TAIL_SDA  = 4'd13;
    localparam logic [3:0] PH_TAIL_HIGH = 4'd14;
    localparam logic [3:0] PH_POLL      = 4'd15;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] func;
        logic [7:0] wdata;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rdata;
        logic       ack_seen;
        logic       ack_timeout;
    } out_item_t;

endpackage

/* rtl/core/i2c_master_byte_engine_core.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine core
// Each accepted tick beat gives its registered result beat in the next cycle.
// Throughput: one tick beat per cycle unless out_ready stalls; the bus
// sequencer state advances once per beat, and the result register frees
// as soon as its beat is taken. Reset: asynchronous, active low; bus idle,
// SCL and SDA released; quarter period back to 5, ACK wait limit to 254.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_byte_engine_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  i2cmbe_pkg::in_item_t                 in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output i2cmbe_pkg::out_item_t                out_data,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [i2cmbe_pkg::QPT_W-1:0]            qpt_reg;
    logic [i2cmbe_pkg::AWL_W-1:0]            awl_reg;

    logic [3:0]                              phase_reg,   phase_next;
    logic [3:0]                              bit_idx_reg, bit_idx_next;
    logic [7:0]                              shift_reg,   shift_next;
    logic [i2cmbe_pkg::TICK_COUNT_WIDTH-1:0] tick_cnt_reg, tick_cnt_next;
    logic [i2cmbe_pkg::AWL_W-1:0]            ack_cnt_reg, ack_cnt_next;
    logic                                    scl_reg,     scl_next;
    logic                                    sda_reg,     sda_next;
    logic [1:0]                              cmd_reg,     cmd_next;
    logic                                    ack_sel_reg, ack_sel_next;
    logic [7:0]                              rdata_reg,   rdata_next;
    logic                                    ack_seen_reg, ack_seen_next;
    logic                                    ack_to_reg,  ack_to_next;
    logic                                    done_next;

    logic                                    out_valid_reg;
    i2cmbe_pkg::out_item_t                   out_data_reg;

    logic                                    in_fire;
    logic [i2cmbe_pkg::QPT_W-1:0]            q_eff;
    logic [i2cmbe_pkg::CMP_W-1:0]            tick_inc_ext;
    logic                                    tick_more;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign q_eff        = (qpt_reg == '0) ? i2cmbe_pkg::QPT_W'(1) : qpt_reg;
    assign tick_inc_ext = i2cmbe_pkg::CMP_W'(tick_cnt_reg) + i2cmbe_pkg::CMP_W'(1);
    assign tick_more    = (tick_inc_ext < i2cmbe_pkg::CMP_W'(q_eff)) && (tick_cnt_reg != '1);

    always_comb
    begin
        logic       enter_step;
        logic [3:0] step;
        logic       wr;
        logic [3:0] bi_inc;

        phase_next    = phase_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        tick_cnt_next = tick_cnt_reg;
        ack_cnt_next  = ack_cnt_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        cmd_next      = cmd_reg;
        ack_sel_next  = ack_sel_reg;
        rdata_next    = rdata_reg;
        ack_seen_next = ack_seen_reg;
        ack_to_next   = ack_to_reg;
        done_next     = 1'b0;
        enter_step    = 1'b0;
        step          = i2cmbe_pkg::PH_IDLE;
        wr            = (cmd_reg == i2cmbe_pkg::CMD_WRITE);
        bi_inc        = bit_idx_reg + 4'd1;

        if (phase_reg == i2cmbe_pkg::PH_IDLE)
        begin
            if (in_data.cmd_valid)
            begin
                cmd_next     = in_data.func;
                ack_sel_next = in_data.send_ack;
                bit_idx_next = '0;
                enter_step   = 1'b1;
                wr           = (in_data.func == i2cmbe_pkg::CMD_WRITE);
                case (in_data.func)
                    i2cmbe_pkg::CMD_START: step = i2cmbe_pkg::PH_ST_A;
                    i2cmbe_pkg::CMD_STOP:  step = i2cmbe_pkg::PH_SP_A;
                    i2cmbe_pkg::CMD_WRITE:
                    begin
                        shift_next    = in_data.wdata;
                        ack_seen_next = 1'b0;
                        ack_to_next   = 1'b0;
                        step          = i2cmbe_pkg::PH_BIT_LOW;
                    end
                    default:
                    begin
                        shift_next = '0;
                        step       = i2cmbe_pkg::PH_ST_A;
                    end
                endcase
            end
        end
        else if (phase_reg == i2cmbe_pkg::PH_POLL)
        begin
            if (!in_data.sda_in)
            begin
                ack_seen_next = 1'b1;
                ack_to_next   = 1'b0;
                scl_next      = 1'b0;
                phase_next    = i2cmbe_pkg::PH_IDLE;
                tick_cnt_next = '0;
                done_next     = 1'b1;
            end
            else if (ack_cnt_reg >= awl_reg)
            begin
                ack_seen_next = 1'b0;
                ack_to_next   = 1'b1;
                scl_next      = 1'b0;
                phase_next    = i2cmbe_pkg::PH_IDLE;
                tick_cnt_next = '0;
                done_next     = 1'b1;
            end
            else
            begin
                ack_cnt_next = ack_cnt_reg + i2cmbe_pkg::AWL_W'(1);
            end
        end
        else if (tick_more)
        begin
            tick_cnt_next = tick_cnt_reg + i2cmbe_pkg::TICK_COUNT_WIDTH'(1);
        end
        else
        begin
            enter_step = 1'b1;
            case (phase_reg)
                i2cmbe_pkg::PH_ST_A:
                    step = (cmd_reg == i2cmbe_pkg::CMD_READ) ? i2cmbe_pkg::PH_BIT_LOW
                                                              : i2cmbe_pkg::PH_ST_B;
                i2cmbe_pkg::PH_ST_B:     step = i2cmbe_pkg::PH_ST_C;
                i2cmbe_pkg::PH_ST_C:     step = i2cmbe_pkg::PH_ST_D;
                i2cmbe_pkg::PH_SP_A:     step = i2cmbe_pkg::PH_SP_B;
                i2cmbe_pkg::PH_SP_B:     step = i2cmbe_pkg::PH_SP_C;
                i2cmbe_pkg::PH_BIT_LOW:
                    step = wr ? i2cmbe_pkg::PH_BIT_SET : i2cmbe_pkg::PH_BIT_HIGH;
                i2cmbe_pkg::PH_BIT_SET:  step = i2cmbe_pkg::PH_BIT_HIGH;
                i2cmbe_pkg::PH_BIT_HIGH:
                begin
                    if (wr)
                    begin
                        shift_next   = {shift_reg[6:0], 1'b0};
                        bit_idx_next = bi_inc;
                        step = (bi_inc >= i2cmbe_pkg::BITS_PER_BYTE) ? i2cmbe_pkg::PH_TAIL_LOW
                                                                     : i2cmbe_pkg::PH_BIT_LOW;
                    end
                    else
                    begin
                        shift_next = {shift_reg[6:0], in_data.sda_in};
                        step       = i2cmbe_pkg::PH_BIT_HOLD;
                    end
                end
                i2cmbe_pkg::PH_BIT_HOLD:
                begin
                    bit_idx_next = bi_inc;
                    step = (bi_inc >= i2cmbe_pkg::BITS_PER_BYTE) ? i2cmbe_pkg::PH_TAIL_LOW
                                                                 : i2cmbe_pkg::PH_BIT_LOW;
                end
                i2cmbe_pkg::PH_TAIL_LOW: step = i2cmbe_pkg::PH_TAIL_SDA;
                i2cmbe_pkg::PH_TAIL_SDA: step = i2cmbe_pkg::PH_TAIL_HIGH;
                i2cmbe_pkg::PH_TAIL_HIGH:
                begin
                    if (wr)
                    begin
                        ack_cnt_next = '0;
                        step         = i2cmbe_pkg::PH_POLL;
                    end
                    else
                    begin
                        rdata_next    = shift_reg;
                        scl_next      = 1'b0;
                        enter_step    = 1'b0;
                        phase_next    = i2cmbe_pkg::PH_IDLE;
                        tick_cnt_next = '0;
                        done_next     = 1'b1;
                    end
                end
                default:
                begin
                    enter_step    = 1'b0;
                    phase_next    = i2cmbe_pkg::PH_IDLE;
                    tick_cnt_next = '0;
                    done_next     = 1'b1;
                end
            endcase
        end

        if (enter_step)
        begin
            phase_next    = step;
            tick_cnt_next = '0;
            case (step)
                i2cmbe_pkg::PH_ST_A:      sda_next = 1'b1;
                i2cmbe_pkg::PH_ST_B:      scl_next = 1'b1;
                i2cmbe_pkg::PH_ST_C:      sda_next = 1'b0;
                i2cmbe_pkg::PH_ST_D:      scl_next = 1'b0;
                i2cmbe_pkg::PH_SP_A:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                i2cmbe_pkg::PH_SP_B:      scl_next = 1'b1;
                i2cmbe_pkg::PH_SP_C:      sda_next = 1'b1;
                i2cmbe_pkg::PH_BIT_LOW:   scl_next = 1'b0;
                i2cmbe_pkg::PH_BIT_SET:   sda_next = shift_next[7];
                i2cmbe_pkg::PH_BIT_HIGH:  scl_next = 1'b1;
                i2cmbe_pkg::PH_TAIL_LOW:  scl_next = 1'b0;
                i2cmbe_pkg::PH_TAIL_SDA:
                    sda_next = (cmd_next == i2cmbe_pkg::CMD_WRITE) ? 1'b1 : !ack_sel_next;
                i2cmbe_pkg::PH_TAIL_HIGH: scl_next = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpt_reg <= i2cmbe_pkg::QPT_W'(5);
            awl_reg <= i2cmbe_pkg::AWL_W'(254);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                i2cmbe_pkg::CFG_QPT: qpt_reg <= cfg_wdata[i2cmbe_pkg::QPT_W-1:0];
                i2cmbe_pkg::CFG_AWL: awl_reg <= cfg_wdata[i2cmbe_pkg::AWL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cmbe_pkg::PH_IDLE;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            tick_cnt_reg  <= '0;
            ack_cnt_reg   <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            cmd_reg       <= i2cmbe_pkg::CMD_START;
            ack_sel_reg   <= 1'b0;
            rdata_reg     <= '0;
            ack_seen_reg  <= 1'b0;
            ack_to_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg    <= phase_next;
                bit_idx_reg  <= bit_idx_next;
                shift_reg    <= shift_next;
                tick_cnt_reg <= tick_cnt_next;
                ack_cnt_reg  <= ack_cnt_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                cmd_reg      <= cmd_next;
                ack_sel_reg  <= ack_sel_next;
                rdata_reg    <= rdata_next;
                ack_seen_reg <= ack_seen_next;
                ack_to_reg   <= ack_to_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg.scl_out     <= scl_next;
            out_data_reg.sda_out     <= sda_next;
            out_data_reg.busy_res    <= (phase_next != i2cmbe_pkg::PH_IDLE);
            out_data_reg.done_res    <= done_next;
            out_data_reg.rdata       <= rdata_next;
            out_data_reg.ack_seen    <= ack_seen_next;
            out_data_reg.ack_timeout <= ack_to_next;
        end
    end

    `ASSERT_PROP(a_idle_cnt_clear, clk, rst_n, (phase_reg == i2cmbe_pkg::PH_IDLE) |-> (tick_cnt_reg == '0))
    `ASSERT_PROP(a_bit_idx_range, clk, rst_n, bit_idx_reg <= i2cmbe_pkg::BITS_PER_BYTE)
    `ASSERT_NEXT(a_fire_gives_beat, clk, rst_n, in_fire, out_valid_reg)
    `ASSERT_PROP(a_done_not_busy, clk, rst_n, (out_valid_reg && out_data_reg.done_res) |-> !out_data_reg.busy_res)
    `ASSERT_PROP(a_ack_flags_excl, clk, rst_n, !(ack_seen_reg && ack_to_reg))

endmodule
